### hdl/syct_pkg.sv
// Package: shared types, codes and sizes for the sorted year count table.
`default_nettype none
package syct_pkg;

  localparam int TABLE_DEPTH = 256;

  localparam int YEAR_W   = 12;
  localparam int AMOUNT_W = 24;
  localparam int TOTAL_W  = 32;
  localparam int VALUE_W  = 33;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_TOTAL  = 2'd2;

  // Group codes
  localparam logic [1:0] GRP_MALE   = 2'd0;
  localparam logic [1:0] GRP_FEMALE = 2'd1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [1:0]          group;
    logic [YEAR_W-1:0]   year;
    logic [AMOUNT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
  } rsp_t;

  // One stored table entry
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [AMOUNT_W-1:0] count;
  } entry_t;

  // Request from the top level to one table
  typedef struct packed {
    logic                insert;
    logic [YEAR_W-1:0]   year;
    logic [AMOUNT_W-1:0] amount;
  } tbl_req_t;

  // Completion report from one table
  typedef struct packed {
    logic                done;
    logic                found;
    logic                full;
    logic [AMOUNT_W-1:0] count;
  } tbl_rsp_t;

endpackage
`default_nettype wire

### hdl/sorted_year_count_table.sv
// Top level: command decode, running totals and result formatting over two tables.
//
// Use:
//   Present a command beat on request and raise start; it is taken at a rising
//   edge where start is high and busy is low. Exactly one result beat follows
//   each command: done is high for one cycle with result.value and
//   result.status, and the receiver cannot hold it off, so it must sample
//   result whenever done is high.
// Sequence (accept edge to done high):
//   total read or unused command code: straight to the result, no table work.
//   lookup: P binary search probes, P at most ceil(log2(used + 1)); each
//     probe is a registered memory read plus a compare.
//     Group "both" searches both tables side by side and waits for the slower.
//   insert: as a lookup, then for a new year the shift moves the entries above
//     the insert point up one place, one entry per cycle, then the new entry is
//     written; a year landing at the end needs only the write. A full table or
//     a year already present ends at the search.
// Throughput: one command at a time; busy drops in the result cycle, so the
//   next beat can be taken at the edge that ends it.
// Reset: synchronous rst empties both tables (fill counts to zero) and clears
//   the totals; the entry memories are not cleared and need no sweep.
`default_nettype none
module sorted_year_count_table #(
  parameter int DEPTH = syct_pkg::TABLE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire syct_pkg::req_t request,
  output logic                done,
  output syct_pkg::rsp_t      result
);
  import syct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_REPLY
  } state_t;

  state_t state;

  logic [1:0]          kind;
  logic                m_pend;
  logic                f_pend;
  logic                m_found;
  logic                f_found;
  logic                m_full;
  logic                f_full;
  logic [AMOUNT_W-1:0] m_cnt;
  logic [AMOUNT_W-1:0] f_cnt;
  logic [VALUE_W-1:0]  tot_val;
  logic [TOTAL_W-1:0]  male_total;
  logic [TOTAL_W-1:0]  female_total;

  logic               accept;
  logic               is_insert;
  logic               is_lookup;
  logic               m_go;
  logic               f_go;
  tbl_req_t           t_req;
  tbl_rsp_t           m_rsp;
  tbl_rsp_t           f_rsp;
  logic [TOTAL_W:0]   m_sum;
  logic [TOTAL_W:0]   f_sum;
  logic [TOTAL_W-1:0] m_sat;
  logic [TOTAL_W-1:0] f_sat;
  logic [VALUE_W-1:0] tot_sel;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    is_insert = (request.command == CMD_INSERT);
    is_lookup = (request.command == CMD_LOOKUP);
    // an insert for any group but male goes to the female table;
    // a lookup for any group but one side searches both
    m_go = accept && ((is_insert && request.group == GRP_MALE) ||
                      (is_lookup && request.group != GRP_FEMALE));
    f_go = accept && ((is_insert && request.group != GRP_MALE) ||
                      (is_lookup && request.group != GRP_MALE));
    t_req = '{insert: is_insert, year: request.year, amount: request.amount};

    // saturating running totals
    m_sum = {1'b0, male_total} + (TOTAL_W + 1)'(request.amount);
    f_sum = {1'b0, female_total} + (TOTAL_W + 1)'(request.amount);
    m_sat = m_sum[TOTAL_W] ? '1 : m_sum[TOTAL_W-1:0];
    f_sat = f_sum[TOTAL_W] ? '1 : f_sum[TOTAL_W-1:0];

    if (request.group == GRP_MALE) begin
      tot_sel = VALUE_W'(male_total);
    end else if (request.group == GRP_FEMALE) begin
      tot_sel = VALUE_W'(female_total);
    end else begin
      tot_sel = VALUE_W'(male_total) + VALUE_W'(female_total);
    end
  end

  syct_table #(
    .DEPTH(DEPTH)
  ) u_male (
    .clk(clk),
    .rst(rst),
    .go (m_go),
    .req(t_req),
    .rsp(m_rsp)
  );

  syct_table #(
    .DEPTH(DEPTH)
  ) u_female (
    .clk(clk),
    .rst(rst),
    .go (f_go),
    .req(t_req),
    .rsp(f_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      m_pend       <= 1'b0;
      f_pend       <= 1'b0;
      male_total   <= '0;
      female_total <= '0;
    end else begin
      done <= 1'b0;

      // hold each table's report until the reply is built
      if (m_rsp.done) begin
        m_found <= m_rsp.found;
        m_full  <= m_rsp.full;
        m_cnt   <= m_rsp.count;
        m_pend  <= 1'b0;
      end
      if (f_rsp.done) begin
        f_found <= f_rsp.found;
        f_full  <= f_rsp.full;
        f_cnt   <= f_rsp.count;
        f_pend  <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind    <= request.command;
            tot_val <= tot_sel;
            m_pend  <= m_go;
            f_pend  <= f_go;
            m_found <= 1'b0;
            f_found <= 1'b0;
            m_full  <= 1'b0;
            f_full  <= 1'b0;
            m_cnt   <= '0;
            f_cnt   <= '0;
            // every insert counts toward its group's total, stored or not
            if (is_insert) begin
              if (request.group == GRP_MALE) begin
                male_total <= m_sat;
              end else begin
                female_total <= f_sat;
              end
            end
            state <= (m_go || f_go) ? S_WAIT : S_REPLY;
          end
        end
        S_WAIT: begin
          if ((!m_pend || m_rsp.done) && (!f_pend || f_rsp.done)) begin
            state <= S_REPLY;
          end
        end
        S_REPLY: begin
          done <= 1'b1;
          unique case (kind)
            CMD_INSERT: begin
              result.value  <= '0;
              result.status <= (m_full || f_full) ? ST_FULL : ST_OK;
            end
            CMD_LOOKUP: begin
              result.value  <= VALUE_W'(m_cnt) + VALUE_W'(f_cnt);
              result.status <= (m_found || f_found) ? ST_OK : ST_NOT_FOUND;
            end
            CMD_TOTAL: begin
              result.value  <= tot_val;
              result.status <= ST_OK;
            end
            default: begin
              result.value  <= '0;
              result.status <= ST_OK;
            end
          endcase
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/syct_table.sv
// One sorted table: entry memory, fill count, binary search and shift-up insert.
`default_nettype none
module syct_table #(
  parameter int DEPTH = syct_pkg::TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire syct_pkg::tbl_req_t req,
  output syct_pkg::tbl_rsp_t      rsp
);
  import syct_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_PUT
  } state_t;

  state_t    state;
  tbl_req_t  op;
  logic [CW-1:0] used;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [CW-1:0] rsrc;
  logic [AW-1:0] wdst;
  logic          rmore;
  logic          pend;

  entry_t mem [DEPTH];
  entry_t rdata;

  logic [CW:0]   lh_sum;
  logic [CW-1:0] mid_calc;
  logic [CW-1:0] rsrc_inc;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;
  entry_t        new_entry;

  always_comb begin
    lh_sum    = {1'b0, lo} + {1'b0, hi};
    mid_calc  = lh_sum[CW:1];
    rsrc_inc  = rsrc + 1'b1;
    new_entry = '{year: op.year, count: op.amount};
    rd_addr   = mid_calc[AW-1:0];
    we        = 1'b0;
    wa        = wdst;
    wd        = rdata;
    unique case (state)
      S_CMP: begin
        // overwrite the count of a year already present
        if (op.insert && rdata.year == op.year) begin
          we = 1'b1;
          wa = mid[AW-1:0];
          wd = new_entry;
        end
      end
      S_SHIFT: begin
        rd_addr = rsrc[AW-1:0];
        if (pend) begin
          we = 1'b1;
        end
      end
      S_PUT: begin
        we = 1'b1;
        wa = lo[AW-1:0];
        wd = new_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      rsp   <= '0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            op    <= req;
            lo    <= '0;
            hi    <= used;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= S_CMP;
          end else if (!op.insert) begin
            rsp   <= '{done: 1'b1, found: 1'b0, full: 1'b0, count: '0};
            state <= S_IDLE;
          end else if (used == FULL_CNT) begin
            rsp   <= '{done: 1'b1, found: 1'b0, full: 1'b1, count: '0};
            state <= S_IDLE;
          end else if (used == lo) begin
            state <= S_PUT;
          end else begin
            rsrc  <= used - 1'b1;
            rmore <= 1'b1;
            pend  <= 1'b0;
            state <= S_SHIFT;
          end
        end
        S_CMP: begin
          if (rdata.year < op.year) begin
            lo    <= mid + 1'b1;
            state <= S_PROBE;
          end else if (rdata.year > op.year) begin
            hi    <= mid;
            state <= S_PROBE;
          end else begin
            rsp   <= '{done: 1'b1, found: 1'b1, full: 1'b0, count: rdata.count};
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          // read walks down from the top entry to the insert point, each entry written one place above
          if (rmore) begin
            pend <= 1'b1;
            wdst <= rsrc_inc[AW-1:0];
            if (rsrc == lo) begin
              rmore <= 1'b0;
            end else begin
              rsrc <= rsrc - 1'b1;
            end
          end else begin
            pend <= 1'b0;
          end
          if (!rmore && pend) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          used  <= used + 1'b1;
          rsp   <= '{done: 1'b1, found: 1'b0, full: 1'b0, count: '0};
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/syct_checker.sv
// Checker: port-level assertions for the sorted year count table, bound to the top level.
`default_nettype none
module syct_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire syct_pkg::req_t request,
  input wire logic           done,
  input wire syct_pkg::rsp_t result
);
  import syct_pkg::*;

  // an accepted beat must make the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // busy only drops when the result beat goes out
  a_drop_with_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy fell without a result beat");

  // no two result beats back to back: one result per command
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

  // an insert dropped on a full table reports no value
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (result.value == '0))
    else $error("table full status with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_NOT_FOUND ||
              result.status == ST_FULL))
    else $error("result status code out of range");

  // request fields are not checked here
  logic unused_req;
  assign unused_req = ^request;

endmodule

bind sorted_year_count_table syct_checker u_syct_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);
`default_nettype wire
